FILE: design/ffud_pkg.sv
// ----------------------------------------------------------------------------
// ffud_pkg
// Shared types and constants of the fixed frame UART deframer.
// ----------------------------------------------------------------------------
package ffud_pkg;

    localparam int FRAME_LENGTH = 32;
    localparam int POS_W        = $clog2(FRAME_LENGTH);
    localparam int STORE_DEPTH  = 16;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam int NUM_MATCH    = 3;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [7:0] HEAD_RESET = 8'hD1;
    localparam logic [7:0] TAIL_RESET = 8'h51;

    localparam logic [POS_W-1:0] TAIL_SLOT = POS_W'(FRAME_LENGTH - 1);

    typedef enum logic [2:0] {
        REG_HEAD_FIRST  = 3'd0,
        REG_HEAD_SECOND = 3'd1,
        REG_HEAD_THIRD  = 3'd2,
        REG_TAIL_FIRST  = 3'd3,
        REG_TAIL_SECOND = 3'd4,
        REG_TAIL_THIRD  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_MATCH-1:0][7:0] head;
        logic [NUM_MATCH-1:0][7:0] tail;
    } t_cfg;

endpackage

FILE: design/ffud_regs.sv
// ----------------------------------------------------------------------------
// ffud_regs
// APB register file holding the head and tail match bytes.
// ----------------------------------------------------------------------------
module ffud_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffud_pkg::ADDR_W-1:0] paddr,
    input  logic [ffud_pkg::DATA_W-1:0] pwdata,
    output logic [ffud_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ffud_pkg::t_cfg              o_cfg
);
    import ffud_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head <= {NUM_MATCH{HEAD_RESET}};
            r_cfg.tail <= {NUM_MATCH{TAIL_RESET}};
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEAD_FIRST:  r_cfg.head[0] <= pwdata[7:0];
                REG_HEAD_SECOND: r_cfg.head[1] <= pwdata[7:0];
                REG_HEAD_THIRD:  r_cfg.head[2] <= pwdata[7:0];
                REG_TAIL_FIRST:  r_cfg.tail[0] <= pwdata[7:0];
                REG_TAIL_SECOND: r_cfg.tail[1] <= pwdata[7:0];
                REG_TAIL_THIRD:  r_cfg.tail[2] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEAD_FIRST:  prdata = DATA_W'(r_cfg.head[0]);
            REG_HEAD_SECOND: prdata = DATA_W'(r_cfg.head[1]);
            REG_HEAD_THIRD:  prdata = DATA_W'(r_cfg.head[2]);
            REG_TAIL_FIRST:  prdata = DATA_W'(r_cfg.tail[0]);
            REG_TAIL_SECOND: prdata = DATA_W'(r_cfg.tail[1]);
            REG_TAIL_THIRD:  prdata = DATA_W'(r_cfg.tail[2]);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/fixed_frame_uart_deframer.sv
// ----------------------------------------------------------------------------
// fixed_frame_uart_deframer
// o_res_valid is registered; set when the tail byte is taken from the input register.
// Throughput: one byte per cycle; the input register feeds the frame tracker,
// which writes the output register. Input stalls only while a result is held
// and a byte already waits in the input register.
// Reset: synchronous, clears frame state, pipeline valids and registers
// to 0xD1 heads / 0x51 tails; the payload bytes are not cleared.
// ----------------------------------------------------------------------------
module fixed_frame_uart_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_rx_valid,
    output logic                        o_rx_stall,
    input  logic [7:0]                  i_rx_byte,
    // frame result channel
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [31:0]                 o_time_stamp,
    output logic [31:0]                 o_packet_index,
    output logic [15:0]                 o_motor_zero,
    output logic [15:0]                 o_motor_one,
    output logic [15:0]                 o_motor_two,
    output logic [15:0]                 o_motor_three,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffud_pkg::ADDR_W-1:0] paddr,
    input  logic [ffud_pkg::DATA_W-1:0] pwdata,
    output logic [ffud_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ffud_pkg::*;

    t_cfg cfg;

    ffud_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: one byte waits here to be checked against the frame state.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame tracker state.
    logic             r_in_frame;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_store [STORE_DEPTH];

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_time_stamp;
    logic [31:0] r_packet_index;
    logic [15:0] r_motor_zero;
    logic [15:0] r_motor_one;
    logic [15:0] r_motor_two;
    logic [15:0] r_motor_three;

    logic             advance;
    logic             take;
    logic             head_hit;
    logic             tail_hit;
    logic             at_tail;
    logic             store_en;
    logic [POS_W-1:0] store_off;
    logic             emit;
    logic             n_in_frame;
    logic [POS_W-1:0] n_pos;

    // The whole pipe moves unless a finished result is held by the consumer.
    assign advance    = !(r_out_valid && i_res_stall);
    assign o_rx_stall = r_in_valid && !advance;
    assign take       = r_in_valid && advance;

    always_comb begin
        head_hit = 1'b0;
        tail_hit = 1'b0;
        for (int k = 0; k < NUM_MATCH; k++) begin
            head_hit = head_hit | (r_in_byte == cfg.head[k]);
            tail_hit = tail_hit | (r_in_byte == cfg.tail[k]);
        end
    end

    assign at_tail   = (r_pos >= TAIL_SLOT);
    assign store_off = r_pos - POS_W'(1);
    // Keep bytes 1..16 of the frame; the rest up to the tail slot only count.
    assign store_en  = take && r_in_frame && !at_tail
                    && (r_pos != '0) && (r_pos <= POS_W'(STORE_DEPTH));

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        emit       = 1'b0;
        if (!r_in_frame) begin
            if (head_hit) begin
                n_in_frame = 1'b1;
                n_pos      = POS_W'(1);
            end
        end else if (at_tail) begin
            // Tail slot: a non-tail drops the frame and is not seen as a head.
            n_in_frame = 1'b0;
            n_pos      = '0;
            emit       = tail_hit;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Refill the input register whenever it is empty or draining.
            if (!o_rx_stall) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_out_valid <= take && emit;
            end
            if (take) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (store_en) begin
            r_store[store_off[STORE_IDX_W-1:0]] <= r_in_byte;
        end
        // Latch the little-endian fields when the frame completes.
        if (take && emit) begin
            r_time_stamp   <= {r_store[3], r_store[2], r_store[1], r_store[0]};
            r_packet_index <= {r_store[7], r_store[6], r_store[5], r_store[4]};
            r_motor_zero   <= {r_store[9], r_store[8]};
            r_motor_one    <= {r_store[11], r_store[10]};
            r_motor_two    <= {r_store[13], r_store[12]};
            r_motor_three  <= {r_store[15], r_store[14]};
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_time_stamp   = r_time_stamp;
    assign o_packet_index = r_packet_index;
    assign o_motor_zero   = r_motor_zero;
    assign o_motor_one    = r_motor_one;
    assign o_motor_two    = r_motor_two;
    assign o_motor_three  = r_motor_three;

    // Position never runs past the tail slot.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= TAIL_SLOT)
        else $error("frame position beyond tail slot");

    // Outside a frame the position rests at zero.
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_pos == '0))
        else $error("position nonzero while waiting for head");

    // A new result only follows a byte taken in the tail slot of a frame.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_in_frame) && ($past(r_pos) == TAIL_SLOT)))
        else $error("result without a completed frame");

    // A stalled input byte stays parked in the input register.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a stalled byte");

endmodule
